[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each macro takes a label, a clock, a reset that disables the check,
// the expression to check and the message text.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

[rtl/core/itce_pkg.sv]
`default_nettype none

package itce_pkg;

   localparam logic [15:0] MAX_COUNT     = 16'hFFFF;
   localparam logic [15:0] PROTO_TCP     = 16'd6;
   localparam logic [15:0] IP_CSUM_POS   = 16'd10;  // IP header checksum word
   localparam logic [15:0] TCP_CSUM_OFS  = 16'd16;  // TCP checksum word, segment offset
   localparam logic [15:0] PSEUDO_FIRST  = 16'd12;  // source address, first word
   localparam logic [15:0] PSEUDO_LAST   = 16'd18;  // destination address, last word
   localparam logic [5:0]  HDR_LEN_RESET = 6'd20;
   localparam logic [5:0]  HDR_LEN_MASK  = 6'h3E;

   // Ones-complement sum of three words with end-around carry.
   function automatic logic [15:0] oc_add3(input logic [15:0] a,
                                           input logic [15:0] b,
                                           input logic [15:0] c);
      logic [17:0] s;
      logic [16:0] f;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c};
      f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      return f[15:0] + {15'd0, f[16]};
   endfunction

endpackage

`default_nettype wire

[rtl/core/ipv4_tcp_checksum_engine_top.sv]
`default_nettype none
// IPv4 / TCP checksum engine.
//
// req_*  : packet bytes in wire order, starting at the first byte of the IP
//          header; req_tlast marks the final byte of a packet.
// rsp_*  : one result per packet, issued after its last byte: complemented
//          IP header checksum, complemented TCP checksum (pseudo header
//          included), packet length and a malformed flag in rsp_tuser.
// csr_*  : IP header length in bytes (bit 0 ignored), reset value 20. Write
//          only between packets.
//
// Throughput is one byte per clock, except that a packet's last byte waits
// while the final stage is full: each byte needs only one 16-bit add per sum
// with end-around carry. A result passes the input register, then packet
// state / final sums, then the result register where the pseudo header tail
// is added. Reset (synchronous, active high) clears all packet state and
// every pipeline stage and reloads the header length with 20.
// When the receiver stalls, the result is held in rsp; bytes that are not a
// packet's last byte keep flowing, and a last byte waits in the input
// register until the final stage frees up.
`include "assert_macros.svh"

module ipv4_tcp_checksum_engine_top
   import itce_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tlast,    // last
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,    // [15:0] ip_checksum, [31:16] tcp_checksum,
                                          // [47:32] packet_length
   output      logic [0:0]  rsp_tuser,    // [0] malformed
   // header length register
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data   // ip_header_len
);

   // header length, low bit already cleared
   logic [5:0]  hl_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   // packet state
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] ip_ff, ip_in;
   logic [15:0] tcp_ff, tcp_in;
   logic [7:0]  held_ff, held_in;
   logic        ovf_ff, ovf_in;

   // final sums of a finished packet
   logic        s2_valid_ff, s2_valid_in;
   logic [15:0] s2_ip_ff, s2_tcp_ff, s2_len_ff;
   logic [5:0]  s2_hl_ff;
   logic        s2_ovf_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff;
   logic        rsp_mal_ff;

   // handshake
   logic        rsp_free, s2_adv, s1_fire, req_fire;

   // word assembly
   logic        sat, take;
   logic [15:0] pos, word, hl_ext;
   logic        ip_en, seg_en, pse_en;
   logic [15:0] ip_next, tcp_next;

   // final stage
   logic [15:0] seg, tcp_fin;
   logic        short_pkt;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign s2_adv     = s2_valid_ff && rsp_free;
   // a last byte needs the final stage to be free (or draining)
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || !s2_valid_ff || s2_adv);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // Word assembly. Every byte is at most one word: an odd byte closes a
   // pair, an even last byte is padded with a zero low byte, and past the
   // saturation point only the held byte is padded on last.
   // ---------------------------------------------------------------------
   assign hl_ext = {10'd0, hl_ff};
   assign sat    = (cnt_ff == MAX_COUNT);
   assign pos    = {cnt_ff[15:1], 1'b0};
   assign take   = sat ? s1_last_ff : (cnt_ff[0] || s1_last_ff);
   assign word   = {cnt_ff[0] ? held_ff : s1_byte_ff,
                    (cnt_ff[0] && !sat) ? s1_byte_ff : 8'd0};

   assign ip_en  = take && (pos < hl_ext) && (pos != IP_CSUM_POS);
   assign seg_en = take && (pos >= hl_ext) && (pos != hl_ext + TCP_CSUM_OFS);
   assign pse_en = take && (pos >= PSEUDO_FIRST) && (pos <= PSEUDO_LAST);

   assign ip_next  = oc_add3(ip_ff, ip_en ? word : 16'd0, 16'd0);
   assign tcp_next = oc_add3(tcp_ff, seg_en ? word : 16'd0, pse_en ? word : 16'd0);

   always_comb begin
      cnt_in  = cnt_ff;
      ip_in   = ip_ff;
      tcp_in  = tcp_ff;
      held_in = held_ff;
      ovf_in  = ovf_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            // packet done: state starts over for the next one
            cnt_in  = '0;
            ip_in   = '0;
            tcp_in  = '0;
            held_in = '0;
            ovf_in  = 1'b0;
         end else begin
            ip_in  = ip_next;
            tcp_in = tcp_next;
            if (sat) begin
               ovf_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 16'd1;
               if (!cnt_ff[0]) begin
                  held_in = s1_byte_ff;
               end
            end
         end
      end
   end

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign s2_valid_in  = (s1_fire && s1_last_ff) || (s2_valid_ff && !s2_adv);
   assign rsp_valid_in = s2_adv || (rsp_valid_ff && !rsp_tready);

   // ---------------------------------------------------------------------
   // Final stage: protocol and segment length go into the TCP sum.
   // ---------------------------------------------------------------------
   assign short_pkt = (s2_len_ff < {10'd0, s2_hl_ff});
   assign seg       = short_pkt ? 16'd0 : (s2_len_ff - {10'd0, s2_hl_ff});
   assign tcp_fin   = oc_add3(s2_tcp_ff, PROTO_TCP, seg);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hl_ff        <= HDR_LEN_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         ip_ff        <= '0;
         tcp_ff       <= '0;
         held_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            hl_ff <= csr_wr_data & HDR_LEN_MASK;
         end
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         ip_ff        <= ip_in;
         tcp_ff       <= tcp_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_fire && s1_last_ff) begin
         s2_ip_ff  <= ip_next;
         s2_tcp_ff <= tcp_next;
         s2_len_ff <= sat ? cnt_ff : cnt_ff + 16'd1;
         s2_hl_ff  <= hl_ff;
         s2_ovf_ff <= ovf_ff || sat;
      end
      if (s2_adv) begin
         rsp_data_ff <= {s2_len_ff, ~tcp_fin, ~s2_ip_ff};
         rsp_mal_ff  <= short_pkt || s2_ovf_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_mal_ff;

   `ASSERT_PROP(a_last_reaches_final, clock, reset, (s1_fire && s1_last_ff) |=> s2_valid_ff, "last request lost before final stage")
   `ASSERT_NEVER(a_final_overrun, clock, reset, s1_fire && s1_last_ff && s2_valid_ff && !s2_adv, "final stage overwritten")
   `ASSERT_PROP(a_state_cleared, clock, reset, (s1_fire && s1_last_ff) |=> (cnt_ff == 16'd0 && ip_ff == 16'd0 && tcp_ff == 16'd0), "packet state not cleared")
   `ASSERT_PROP(a_saturate_flags, clock, reset, (sat && s1_fire && !s1_last_ff) |=> (ovf_ff && cnt_ff == MAX_COUNT), "saturated count moved or flag missing")

endmodule

`default_nettype wire
